// ===== sv/etm_pkg.sv =====
// shared types, constants and arithmetic helpers of the euler transform matrix unit
package etm_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int TRIG_STAGES_DEF = 16;

   localparam int ANG_W   = 16;
   localparam int FIELD_W = 32;
   localparam int NUM_W   = 34;
   localparam int DIV_STAGES = NUM_W;
   localparam int ANG_SHIFT  = 17;

   localparam logic       OP_MODEL  = 1'b0;
   localparam logic       OP_NORMAL = 1'b1;
   localparam logic [1:0] COL_LAST_MODEL  = 2'd3;
   localparam logic [1:0] COL_LAST_NORMAL = 2'd2;
   localparam logic [1:0] COL_TRANS       = 2'd3;

   localparam logic signed [33:0] Q30_HALF_PI  = 34'sd1686629713;
   localparam logic signed [33:0] Q30_PI       = 34'sd3373259426;
   localparam logic signed [31:0] Q30_INV_GAIN = 32'sh26DD3B6A;
   localparam logic [33:0]        NUM_BASE     = 34'h1_0000_0000;
   localparam logic [31:0]        RECIP_SAT    = 32'h7FFF_FFFF;
   localparam logic [31:0]        RECIP_MIN    = 32'h8000_0000;
   localparam logic [31:0]        ONE_Q16      = 32'h0001_0000;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        neg;
   } cordic_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [33:0] num;
      logic [33:0] quo;
      logic [31:0] mag;
      logic        sgn;
      logic        zero;
   } div_type;

   // angle slot 0 = y, 1 = x, 2 = z
   typedef struct packed {
      logic                 valid;
      logic                 op;
      cordic_type [2:0]     cor;
      div_type    [2:0]     div;
      logic [2:0][31:0]     trans;
   } iter_type;

   typedef struct packed {
      logic             valid;
      logic             op;
      logic [32:0]      s2;
      logic [32:0]      s3;
      logic [32:0]      c1c3;
      logic [32:0]      s1s2;
      logic [32:0]      c1s2;
      logic [32:0]      c3s1;
      logic [32:0]      c2s3;
      logic [32:0]      c2c3;
      logic [32:0]      c2s1;
      logic [32:0]      s1s3;
      logic [32:0]      c1c2;
      logic [32:0]      c1s3;
      logic [2:0][31:0] fac;
      logic [2:0]       zf;
      logic [2:0][31:0] trans;
   } m1_type;

   typedef struct packed {
      logic             valid;
      logic             op;
      logic [32:0]      s2;
      logic [32:0]      t_s1s2s3;
      logic [32:0]      t_c1s2s3;
      logic [32:0]      t_c3s1s2;
      logic [32:0]      t_c1c3s2;
      logic [32:0]      c1c3;
      logic [32:0]      c3s1;
      logic [32:0]      c2s3;
      logic [32:0]      c2c3;
      logic [32:0]      c2s1;
      logic [32:0]      s1s3;
      logic [32:0]      c1c2;
      logic [32:0]      c1s3;
      logic [2:0][31:0] fac;
      logic [2:0]       zf;
      logic [2:0][31:0] trans;
   } m2_type;

   // r indexed [row][col]
   typedef struct packed {
      logic                  valid;
      logic                  op;
      logic [2:0][2:0][33:0] r;
      logic [2:0][31:0]      fac;
      logic [2:0]            zf;
      logic [2:0][31:0]      trans;
   } mat_type;

   // q2.30 product rounded back to q2.30
   function automatic logic [32:0] mul30(input logic [32:0] a, input logic [32:0] b);
      logic signed [65:0] p;
      p = $signed(a) * $signed(b);
      p = p + (66'sd1 <<< 29);
      return p[62:30];
   endfunction

endpackage

// ===== sv/etm_iter_stage.sv =====
// one step: one quotient bit per reciprocal, cordic rotation per angle if STAGE < TRIG_STAGES
module etm_iter_stage #(
   parameter int STAGE       = 0,
   parameter int TRIG_STAGES = etm_pkg::TRIG_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  etm_pkg::iter_type stg_in,
   output etm_pkg::iter_type stg_ff
);

   localparam bit DO_ROT = (STAGE < TRIG_STAGES) && (STAGE < 32);
   localparam int SH     = DO_ROT ? STAGE : 0;

   etm_pkg::iter_type stg_nxt;

   always_comb begin
      stg_nxt = stg_in;
      for (int a = 0; a < 3; a++) begin
         logic [32:0] r2;
         logic [32:0] diff;
         logic        qb;
         logic [31:0] dx;
         logic [31:0] dy;
         r2   = {stg_in.div[a].rem, stg_in.div[a].num[etm_pkg::NUM_W-1]};
         diff = r2 - {1'b0, stg_in.div[a].mag};
         qb   = (r2 >= {1'b0, stg_in.div[a].mag});
         stg_nxt.div[a].rem = qb ? diff[31:0] : r2[31:0];
         stg_nxt.div[a].num = {stg_in.div[a].num[etm_pkg::NUM_W-2:0], 1'b0};
         stg_nxt.div[a].quo = {stg_in.div[a].quo[etm_pkg::NUM_W-2:0], qb};

         dx = $signed(stg_in.cor[a].y) >>> SH;
         dy = $signed(stg_in.cor[a].x) >>> SH;
         if (DO_ROT) begin
            if (!stg_in.cor[a].z[31]) begin
               stg_nxt.cor[a].x = stg_in.cor[a].x - dx;
               stg_nxt.cor[a].y = stg_in.cor[a].y + dy;
               stg_nxt.cor[a].z = stg_in.cor[a].z - etm_pkg::ATAN_Q30[SH];
            end else begin
               stg_nxt.cor[a].x = stg_in.cor[a].x + dx;
               stg_nxt.cor[a].y = stg_in.cor[a].y - dy;
               stg_nxt.cor[a].z = stg_in.cor[a].z + etm_pkg::ATAN_Q30[SH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.valid <= 1'b0;
      end else if (en) begin
         stg_ff <= stg_nxt;
      end
   end

endmodule

// ===== sv/etm_matrix.sv =====
// three register stages that build the rotation matrix and the column factors
module etm_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  etm_pkg::iter_type iter_in,
   output etm_pkg::mat_type  mat_ff
);

   etm_pkg::m1_type  m1_in, m1_ff;
   etm_pkg::m2_type  m2_in, m2_ff;
   etm_pkg::mat_type mat_in;

   logic [2:0][32:0] sn;
   logic [2:0][32:0] cs;

   // sign fold for angles that were moved by pi, then the pair products and the column factors
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic [32:0] xe;
         logic [32:0] ye;
         xe = {iter_in.cor[a].x[31], iter_in.cor[a].x};
         ye = {iter_in.cor[a].y[31], iter_in.cor[a].y};
         cs[a] = iter_in.cor[a].neg ? 33'd0 - xe : xe;
         sn[a] = iter_in.cor[a].neg ? 33'd0 - ye : ye;
      end
      m1_in.valid = iter_in.valid;
      m1_in.op    = iter_in.op;
      m1_in.s2    = sn[1];
      m1_in.s3    = sn[2];
      m1_in.c1c3  = etm_pkg::mul30(cs[0], cs[2]);
      m1_in.s1s2  = etm_pkg::mul30(sn[0], sn[1]);
      m1_in.c1s2  = etm_pkg::mul30(cs[0], sn[1]);
      m1_in.c3s1  = etm_pkg::mul30(cs[2], sn[0]);
      m1_in.c2s3  = etm_pkg::mul30(cs[1], sn[2]);
      m1_in.c2c3  = etm_pkg::mul30(cs[1], cs[2]);
      m1_in.c2s1  = etm_pkg::mul30(cs[1], sn[0]);
      m1_in.s1s3  = etm_pkg::mul30(sn[0], sn[2]);
      m1_in.c1c2  = etm_pkg::mul30(cs[0], cs[1]);
      m1_in.c1s3  = etm_pkg::mul30(cs[0], sn[2]);
      m1_in.trans = iter_in.trans;
      for (int j = 0; j < 3; j++) begin
         logic [33:0] q;
         q = iter_in.div[j].quo;
         m1_in.zf[j] = 1'b0;
         if (iter_in.op == etm_pkg::OP_MODEL) begin
            m1_in.fac[j] = iter_in.div[j].sgn ? 32'd0 - iter_in.div[j].mag
                                              : iter_in.div[j].mag;
         end else if (iter_in.div[j].zero) begin
            m1_in.fac[j] = etm_pkg::RECIP_SAT;
            m1_in.zf[j]  = 1'b1;
         end else if (!iter_in.div[j].sgn) begin
            m1_in.fac[j] = (q > {2'b00, etm_pkg::RECIP_SAT}) ? etm_pkg::RECIP_SAT : q[31:0];
         end else begin
            m1_in.fac[j] = (q > {2'b00, etm_pkg::RECIP_MIN}) ? etm_pkg::RECIP_MIN
                                                             : 32'd0 - q[31:0];
         end
      end
   end

   // triple products
   always_comb begin
      m2_in.valid    = m1_ff.valid;
      m2_in.op       = m1_ff.op;
      m2_in.s2       = m1_ff.s2;
      m2_in.t_s1s2s3 = etm_pkg::mul30(m1_ff.s1s2, m1_ff.s3);
      m2_in.t_c1s2s3 = etm_pkg::mul30(m1_ff.c1s2, m1_ff.s3);
      m2_in.t_c3s1s2 = etm_pkg::mul30(m1_ff.c3s1, m1_ff.s2);
      m2_in.t_c1c3s2 = etm_pkg::mul30(m1_ff.c1c3, m1_ff.s2);
      m2_in.c1c3     = m1_ff.c1c3;
      m2_in.c3s1     = m1_ff.c3s1;
      m2_in.c2s3     = m1_ff.c2s3;
      m2_in.c2c3     = m1_ff.c2c3;
      m2_in.c2s1     = m1_ff.c2s1;
      m2_in.s1s3     = m1_ff.s1s3;
      m2_in.c1c2     = m1_ff.c1c2;
      m2_in.c1s3     = m1_ff.c1s3;
      m2_in.fac      = m1_ff.fac;
      m2_in.zf       = m1_ff.zf;
      m2_in.trans    = m1_ff.trans;
   end

   function automatic logic [33:0] ext(input logic [32:0] v);
      return {v[32], v};
   endfunction

   // matrix sums
   always_comb begin
      mat_in.valid   = m2_ff.valid;
      mat_in.op      = m2_ff.op;
      mat_in.r[0][0] = ext(m2_ff.c1c3) + ext(m2_ff.t_s1s2s3);
      mat_in.r[1][0] = ext(m2_ff.c2s3);
      mat_in.r[2][0] = ext(m2_ff.t_c1s2s3) - ext(m2_ff.c3s1);
      mat_in.r[0][1] = ext(m2_ff.t_c3s1s2) - ext(m2_ff.c1s3);
      mat_in.r[1][1] = ext(m2_ff.c2c3);
      mat_in.r[2][1] = ext(m2_ff.t_c1c3s2) + ext(m2_ff.s1s3);
      mat_in.r[0][2] = ext(m2_ff.c2s1);
      mat_in.r[1][2] = 34'd0 - ext(m2_ff.s2);
      mat_in.r[2][2] = ext(m2_ff.c1c2);
      mat_in.fac     = m2_ff.fac;
      mat_in.zf      = m2_ff.zf;
      mat_in.trans   = m2_ff.trans;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.valid  <= 1'b0;
         m2_ff.valid  <= 1'b0;
         mat_ff.valid <= 1'b0;
      end else if (en) begin
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         mat_ff <= mat_in;
      end
   end

endmodule

// ===== sv/etm_column.sv =====
// column sequencer: scales or copies one column per beat into the result register
module etm_column #(
   parameter int DATA_WIDTH = etm_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  etm_pkg::mat_type        mat_in,
   output logic                    ser_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_column,
   output logic signed [31:0]      rsp_elem0,
   output logic signed [31:0]      rsp_elem1,
   output logic signed [31:0]      rsp_elem2,
   output logic signed [31:0]      rsp_elem3,
   output logic                    rsp_last,
   output logic                    rsp_zero_scale
);

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   function automatic logic [31:0] sat(input logic signed [63:0] v);
      logic signed [63:0] t;
      if (v > SAT_HI) t = SAT_HI;
      else if (v < SAT_LO) t = SAT_LO;
      else t = v;
      return t[31:0];
   endfunction

   etm_pkg::mat_type item_ff;
   logic             ser_valid_ff, ser_valid_in;
   logic [1:0]       col_ff, col_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_col_ff;
   logic [3:0][31:0] out_elem_ff, out_elem_in;
   logic             out_last_ff, out_last_in;
   logic             out_zf_ff, out_zf_in;

   logic             out_can, beat, is_last;
   logic [2:0][33:0] rsel;
   logic [31:0]      fsel;
   logic             zsel;

   assign out_can = !out_valid_ff || rsp_ready;
   assign beat    = ser_valid_ff && out_can;
   assign is_last = col_ff == ((item_ff.op == etm_pkg::OP_NORMAL) ? etm_pkg::COL_LAST_NORMAL
                                                                 : etm_pkg::COL_LAST_MODEL);
   assign ser_ready = !ser_valid_ff || (beat && is_last);

   always_comb begin
      unique case (col_ff)
         2'd1: begin
            for (int k = 0; k < 3; k++) rsel[k] = item_ff.r[k][1];
            fsel = item_ff.fac[1];
            zsel = item_ff.zf[1];
         end
         2'd2: begin
            for (int k = 0; k < 3; k++) rsel[k] = item_ff.r[k][2];
            fsel = item_ff.fac[2];
            zsel = item_ff.zf[2];
         end
         default: begin
            for (int k = 0; k < 3; k++) rsel[k] = item_ff.r[k][0];
            fsel = item_ff.fac[0];
            zsel = item_ff.zf[0];
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [65:0] p;
         logic [35:0]        v;
         p = $signed(rsel[k]) * $signed(fsel);
         p = p + (66'sd1 <<< 29);
         v = p[65:30];
         if (col_ff == etm_pkg::COL_TRANS) begin
            out_elem_in[k] = sat({{32{item_ff.trans[k][31]}}, item_ff.trans[k]});
         end else begin
            out_elem_in[k] = sat({{28{v[35]}}, v});
         end
      end
      out_elem_in[3] = (col_ff == etm_pkg::COL_TRANS) ? etm_pkg::ONE_Q16 : 32'd0;
      out_zf_in      = (col_ff == etm_pkg::COL_TRANS) ? 1'b0 : zsel;
      out_last_in    = is_last;
      out_valid_in   = out_can ? beat : out_valid_ff;
      ser_valid_in   = ser_ready ? mat_in.valid : ser_valid_ff;
      col_in         = ser_ready ? 2'd0 : (beat ? col_ff + 2'd1 : col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         col_ff       <= 2'd0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         out_valid_ff <= out_valid_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_ready) item_ff <= mat_in;
      if (beat) begin
         out_col_ff  <= col_ff;
         out_elem_ff <= out_elem_in;
         out_last_ff <= out_last_in;
         out_zf_ff   <= out_zf_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_column     = out_col_ff;
   assign rsp_elem0      = out_elem_ff[0];
   assign rsp_elem1      = out_elem_ff[1];
   assign rsp_elem2      = out_elem_ff[2];
   assign rsp_elem3      = out_elem_ff[3];
   assign rsp_last       = out_last_ff;
   assign rsp_zero_scale = out_zf_ff;

endmodule

// ===== sv/euler_transform_matrix_unit.sv =====
// top level of the euler transform matrix unit
// from an accepted req beat to its first rsp beat: prep loads on the accepting edge,
// then come 34 divider steps (cordic in the first TRIG_STAGES), 3 matrix stages, the sequencer and the result register
// throughput: one rsp beat per cycle while rsp_ready is held; 4 column beats per model matrix,
// 3 per normal matrix; req beats are taken every cycle unless the whole pipe stalls
// reset: synchronous, clears all valid bits; the unit holds no state between items
module euler_transform_matrix_unit #(
   parameter int DATA_WIDTH  = etm_pkg::DATA_WIDTH_DEF,
   parameter int TRIG_STAGES = etm_pkg::TRIG_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [15:0] req_rot_x,
   input  logic signed [15:0] req_rot_y,
   input  logic signed [15:0] req_rot_z,
   input  logic signed [31:0] req_scale_x,
   input  logic signed [31:0] req_scale_y,
   input  logic signed [31:0] req_scale_z,
   input  logic signed [31:0] req_trans_x,
   input  logic signed [31:0] req_trans_y,
   input  logic signed [31:0] req_trans_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_column,
   output logic signed [31:0] rsp_elem0,
   output logic signed [31:0] rsp_elem1,
   output logic signed [31:0] rsp_elem2,
   output logic signed [31:0] rsp_elem3,
   output logic               rsp_last,
   output logic               rsp_zero_scale
);

   // whole pipe moves together; it stalls only when the sequencer is busy and the matrix stage holds a valid item
   logic en;
   logic ser_ready;

   etm_pkg::iter_type stg [etm_pkg::DIV_STAGES+1];
   etm_pkg::iter_type prep_in, prep_ff;
   etm_pkg::mat_type  mat;

   logic [2:0][15:0] rot;
   logic [2:0][31:0] scl;

   assign en        = !mat.valid || ser_ready;
   assign req_ready = en;

   // angle slots follow the rotation order: y first, then x, then z
   assign rot[0] = req_rot_y;
   assign rot[1] = req_rot_x;
   assign rot[2] = req_rot_z;
   assign scl[0] = req_scale_x;
   assign scl[1] = req_scale_y;
   assign scl[2] = req_scale_z;

   // prep: angle to q2.30 folded into +-pi/2, divider operands |s| and 2^32 + |s|/2
   always_comb begin
      prep_in.valid    = req_valid;
      prep_in.op       = req_op;
      prep_in.trans[0] = req_trans_x;
      prep_in.trans[1] = req_trans_y;
      prep_in.trans[2] = req_trans_z;
      for (int a = 0; a < 3; a++) begin
         logic signed [33:0] z34;
         logic signed [33:0] zr;
         logic [31:0]        mag;
         z34 = $signed({rot[a][15], rot[a], {etm_pkg::ANG_SHIFT{1'b0}}});
         prep_in.cor[a].neg = 1'b1;
         if (z34 > etm_pkg::Q30_HALF_PI) begin
            zr = z34 - etm_pkg::Q30_PI;
         end else if (z34 < -etm_pkg::Q30_HALF_PI) begin
            zr = z34 + etm_pkg::Q30_PI;
         end else begin
            zr = z34;
            prep_in.cor[a].neg = 1'b0;
         end
         prep_in.cor[a].x = etm_pkg::Q30_INV_GAIN;
         prep_in.cor[a].y = 32'd0;
         prep_in.cor[a].z = zr[31:0];

         mag = scl[a][31] ? 32'd0 - scl[a] : scl[a];
         prep_in.div[a].mag  = mag;
         prep_in.div[a].sgn  = scl[a][31];
         prep_in.div[a].zero = (scl[a] == 32'd0);
         prep_in.div[a].rem  = 32'd0;
         prep_in.div[a].quo  = '0;
         prep_in.div[a].num  = etm_pkg::NUM_BASE + {3'b000, mag[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign stg[0] = prep_ff;

   // one quotient bit per stage, and one cordic step in each of the first TRIG_STAGES stages
   for (genvar i = 0; i < etm_pkg::DIV_STAGES; i++) begin : g_iter
      etm_iter_stage #(
         .STAGE       (i),
         .TRIG_STAGES (TRIG_STAGES)
      ) u_iter (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .stg_in (stg[i]),
         .stg_ff (stg[i+1])
      );
   end

   etm_matrix u_matrix (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .iter_in (stg[etm_pkg::DIV_STAGES]),
      .mat_ff  (mat)
   );

   // column beats out through a result register, so a new item can load while one waits
   etm_column #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_column (
      .clock          (clock),
      .reset          (reset),
      .mat_in         (mat),
      .ser_ready      (ser_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_column     (rsp_column),
      .rsp_elem0      (rsp_elem0),
      .rsp_elem1      (rsp_elem1),
      .rsp_elem2      (rsp_elem2),
      .rsp_elem3      (rsp_elem3),
      .rsp_last       (rsp_last),
      .rsp_zero_scale (rsp_zero_scale)
   );

endmodule

// ===== tb/tb_euler_transform_matrix_unit.sv =====
// testbench for the euler transform matrix unit: random and corner beats checked against a predictor
`timescale 1ns / 1ps

typedef struct packed {
   logic [1:0]  column;
   logic [31:0] elem0;
   logic [31:0] elem1;
   logic [31:0] elem2;
   logic [31:0] elem3;
   logic        last;
   logic        zero_scale;
} column_type;

class etm_scoreboard;
   column_type  column_q[$];
   int unsigned mismatch_count;
   int unsigned column_count;
   int unsigned matrix_count;
   int unsigned zero_scale_count;

   function new();
      mismatch_count = 0;
      column_count = 0;
      matrix_count = 0;
      zero_scale_count = 0;
   endfunction

   static function longint asr(longint v, int s);
      return v >>> s;
   endfunction

   static function longint q30_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   static function void sin_cos(logic signed [15:0] ang, output longint sn, output longint cs);
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'(ang) * 131072;
      x = longint'(etm_pkg::Q30_INV_GAIN);
      y = 0;
      flip = 0;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426; flip = 1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426; flip = 1;
      end
      for (int i = 0; i < etm_pkg::TRIG_STAGES_DEF; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(etm_pkg::ATAN_Q30[i]);
         end else begin
            x += dx; y -= dy; z += longint'(etm_pkg::ATAN_Q30[i]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      sn = y;
      cs = x;
   endfunction

   static function longint recip(longint s);
      longint mag, q;
      mag = s < 0 ? -s : s;
      q = ((64'sd1 <<< 32) + (mag >>> 1)) / mag;
      if (s > 0) return q > 64'sh7FFFFFFF ? 64'sh7FFFFFFF : q;
      return q > 64'sh80000000 ? -64'sh80000000 : -q;
   endfunction

   // note one accepted request beat and queue its columns
   function void note_request(logic op, logic signed [15:0] rx, logic signed [15:0] ry,
                              logic signed [15:0] rz, logic signed [31:0] sc[3],
                              logic signed [31:0] tr[3]);
      longint     s1, c1, s2, c2, s3, c3, fac[3];
      longint     r[3][3];
      bit         zf[3];
      int         ncol;
      column_type c;
      sin_cos(ry, s1, c1);
      sin_cos(rx, s2, c2);
      sin_cos(rz, s3, c3);
      r[0][0] = q30_mul(c1, c3) + q30_mul(q30_mul(s1, s2), s3);
      r[1][0] = q30_mul(c2, s3);
      r[2][0] = q30_mul(q30_mul(c1, s2), s3) - q30_mul(c3, s1);
      r[0][1] = q30_mul(q30_mul(c3, s1), s2) - q30_mul(c1, s3);
      r[1][1] = q30_mul(c2, c3);
      r[2][1] = q30_mul(q30_mul(c1, c3), s2) + q30_mul(s1, s3);
      r[0][2] = q30_mul(c2, s1);
      r[1][2] = -s2;
      r[2][2] = q30_mul(c1, c2);
      for (int j = 0; j < 3; j++) begin
         zf[j] = 0;
         if (op == etm_pkg::OP_MODEL) fac[j] = longint'(sc[j]);
         else if (sc[j] == 0) begin
            fac[j] = 64'sh7FFFFFFF; zf[j] = 1;
         end else fac[j] = recip(longint'(sc[j]));
      end
      ncol = op == etm_pkg::OP_MODEL ? 4 : 3;
      for (int j = 0; j < ncol; j++) begin
         c.column = j[1:0];
         if (j < 3) begin
            c.elem0 = sat32((r[0][j] * fac[j] + (64'sd1 <<< 29)) >>> 30);
            c.elem1 = sat32((r[1][j] * fac[j] + (64'sd1 <<< 29)) >>> 30);
            c.elem2 = sat32((r[2][j] * fac[j] + (64'sd1 <<< 29)) >>> 30);
            c.elem3 = '0;
            c.zero_scale = zf[j];
         end else begin
            c.elem0 = tr[0];
            c.elem1 = tr[1];
            c.elem2 = tr[2];
            c.elem3 = etm_pkg::ONE_Q16;
            c.zero_scale = 0;
         end
         c.last = (j == ncol - 1);
         column_q.push_back(c);
      end
      matrix_count++;
   endfunction

   // compare one response beat against the oldest pending column
   function void check_column(column_type got);
      column_type want;
      column_count++;
      if (got.zero_scale) zero_scale_count++;
      if (column_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected rsp beat, column %0d", got.column);
         return;
      end
      want = column_q.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: exp col %0d %h %h %h %h last %b zs %b, got col %0d %h %h %h %h last %b zs %b",
                     want.column, want.elem0, want.elem1, want.elem2, want.elem3, want.last,
                     want.zero_scale, got.column, got.elem0, got.elem1, got.elem2, got.elem3,
                     got.last, got.zero_scale);
      end
   endfunction
endclass

module tb_euler_transform_matrix_unit;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_op = 0;
   logic signed [15:0] req_rot_x = 0, req_rot_y = 0, req_rot_z = 0;
   logic signed [31:0] req_scale_x = 0, req_scale_y = 0, req_scale_z = 0;
   logic signed [31:0] req_trans_x = 0, req_trans_y = 0, req_trans_z = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [1:0]         rsp_column;
   logic signed [31:0] rsp_elem0, rsp_elem1, rsp_elem2, rsp_elem3;
   logic               rsp_last, rsp_zero_scale;

   // idle percentages per side, changed phase by phase
   int unsigned send_idle_pct = 9;
   int unsigned recv_idle_pct = 86;

   etm_scoreboard matrix_sb = new();

   always #2 clock = ~clock;

   euler_transform_matrix_unit dut (.*);

   // receiver: random back-pressure, check every accepted beat
   always @(posedge clock) begin
      column_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.column = rsp_column;
         got.elem0 = rsp_elem0;
         got.elem1 = rsp_elem1;
         got.elem2 = rsp_elem2;
         got.elem3 = rsp_elem3;
         got.last = rsp_last;
         got.zero_scale = rsp_zero_scale;
         matrix_sb.check_column(got);
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // send one request beat and hold it until the dut takes it
   task automatic send_matrix(logic op, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                              logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                              logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
      logic signed [31:0] sc[3];
      logic signed [31:0] tr[3];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_rot_x <= rx; req_rot_y <= ry; req_rot_z <= rz;
      req_scale_x <= sx; req_scale_y <= sy; req_scale_z <= sz;
      req_trans_x <= tx; req_trans_y <= ty; req_trans_z <= tz;
      do @(posedge clock); while (!req_ready);
      sc = '{sx, sy, sz};
      tr = '{tx, ty, tz};
      matrix_sb.note_request(op, rx, ry, rz, sc, tr);
   endtask

   // mostly moderate values with some full-range and zero scales
   function automatic logic [31:0] pick_scale();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom();
         2: return $urandom_range(3) - 1;
         default: return 32'($signed($urandom_range(8 << 16))) - (4 << 16);
      endcase
   endfunction

   task automatic send_random();
      send_matrix($urandom_range(1), $urandom(), $urandom(), $urandom(),
                  pick_scale(), pick_scale(), pick_scale(), $urandom(), $urandom(), $urandom());
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (matrix_sb.column_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners: angle extremes and quadrant folds, scale extremes, zero scale
      send_matrix(etm_pkg::OP_MODEL, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
      send_matrix(etm_pkg::OP_NORMAL, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
      send_matrix(etm_pkg::OP_MODEL, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFFFFFF, 32'h80000000,
                  32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
      send_matrix(etm_pkg::OP_NORMAL, 16'h8000, 16'h7FFF, 16'h8000, 32'h7FFFFFFF,
                  32'h80000000, 32'hFFFFFFFF, 0, 0, 0);
      send_matrix(etm_pkg::OP_NORMAL, 16'd12868, 16'hCDBC, 16'd12869, 0, 0, 0, 1, 2, 3);
      send_matrix(etm_pkg::OP_NORMAL, 16'h3244, 16'hCDBB, 16'hFFFF, 1, 32'hFFFFFFFF, 0,
                  0, 0, 0);
      send_matrix(etm_pkg::OP_NORMAL, 16'd25736, 16'hFFFF, 16'd6434, 2, 32'hFFFFFFFE,
                  32'h20000, 0, 0, 0);
      send_matrix(etm_pkg::OP_MODEL, 16'd6434, 16'd25736, 16'hE6DE, 32'h80000000, 0, 1,
                  32'h12345678, 32'hFEDCBA98, 32'h55555555);
      send_matrix(etm_pkg::OP_MODEL, 16'hAAAA, 16'h5555, 16'hAAAA, 32'hAAAAAAAA, 32'h55555555,
                  32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
      send_matrix(etm_pkg::OP_NORMAL, 16'h5555, 16'hAAAA, 16'h5555, 32'h55555555,
                  32'hAAAAAAAA, 32'h55555555, 0, 0, 0);
      wait_drained();

      // random phases with shifting idle pattern; pause for a full drain between them
      repeat (140) send_random();
      wait_drained();
      send_idle_pct = 86;
      recv_idle_pct = 9;
      repeat (130) send_random();
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (130) send_random();

      wait_drained();
      repeat (60) @(posedge clock);
      $display("covered %0d matrices, %0d column beats, %0d zero-scale columns",
               matrix_sb.matrix_count, matrix_sb.column_count, matrix_sb.zero_scale_count);
      if (matrix_sb.mismatch_count == 0 && matrix_sb.column_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d columns missing", matrix_sb.mismatch_count,
                  matrix_sb.column_q.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #4000000;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
sv/etm_pkg.sv
sv/etm_iter_stage.sv
sv/etm_matrix.sv
sv/etm_column.sv
sv/euler_transform_matrix_unit.sv
tb/tb_euler_transform_matrix_unit.sv
